// File: rtl/bfpm_pkg.sv
// Shared constants, field widths and controller/datapath signal groups of the flow pulse meter.
package bfpm_pkg;

  localparam int KIND_W     = 2;
  localparam int WIN_W      = 10;
  localparam int PPL_W      = 10;
  localparam int SES_W      = 16;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SESSION_MS = 2'd2;

  localparam logic [WIN_W-1:0] WIN_RST = 10'd100;
  localparam logic [PPL_W-1:0] PPL_RST = 10'd50;
  localparam logic [SES_W-1:0] SES_RST = 16'd10000;

  localparam int FLOW_SCALE_W = 20;
  localparam int VOL_SCALE_W  = 10;
  localparam int DIVISOR_W    = WIN_W + PPL_W;

  localparam logic [FLOW_SCALE_W-1:0] FLOW_SCALE = 20'd1000000;
  localparam logic [VOL_SCALE_W-1:0]  VOL_SCALE  = 10'd1000;

  localparam logic [OUT_W-1:0] I32_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] I32_MIN = 32'h8000_0000;

  typedef struct packed {
    logic accept;
    logic load_mul;
    logic div_start;
    logic div_sel_vol;
    logic cap_flow;
    logic cap_vol;
    logic commit_vol;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic window_end;
    logic div_done;
  } sts_t;

endpackage

// File: rtl/bfpm_if.sv
// Handshake interfaces for the sample, result and configuration channels.
interface bfpm_in_if;
  import bfpm_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              pin_a;
  logic              pin_b;
  logic              ms_tick;
  modport source (output valid, kind, pin_a, pin_b, ms_tick, input ready);
  modport sink (input valid, kind, pin_a, pin_b, ms_tick, output ready);
endinterface

interface bfpm_out_if;
  import bfpm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] flow_ml_per_s;
  logic signed [OUT_W-1:0] volume_ml;
  logic [SES_W-1:0]        elapsed_ms;
  logic                    session_end;
  modport source (output valid, flow_ml_per_s, volume_ml, elapsed_ms, session_end,
                  input ready);
  modport sink (input valid, flow_ml_per_s, volume_ml, elapsed_ms, session_end,
                output ready);
endinterface

interface bfpm_cfg_if;
  import bfpm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/bfpm_div.sv
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module bfpm_div #(
  parameter int DVD_W = 36,
  parameter int DVS_W = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem_r, q_r[DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(DVD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

// File: rtl/bfpm_ctrl.sv
// Controller state machine that sequences the window-end computation and the result register.
module bfpm_ctrl
  import bfpm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_FSTART,
    S_FWAIT,
    S_VSTART,
    S_VWAIT,
    S_VOL,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && sts.window_end) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.load_mul = 1'b1;
        state_nxt    = S_FSTART;
      end
      S_FSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_FWAIT;
      end
      S_FWAIT: begin
        if (sts.div_done) begin
          cmd.cap_flow = 1'b1;
          state_nxt    = S_VSTART;
        end
      end
      S_VSTART: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel_vol = 1'b1;
        state_nxt       = S_VWAIT;
      end
      S_VWAIT: begin
        cmd.div_sel_vol = 1'b1;
        if (sts.div_done) begin
          cmd.cap_vol = 1'b1;
          state_nxt   = S_VOL;
        end
      end
      S_VOL: begin
        cmd.commit_vol = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.emit || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/bfpm_dp.sv
// Datapath: configuration, pulse and timer state, flow and volume arithmetic, result word.
module bfpm_dp
  import bfpm_pkg::*;
#(
  parameter int COUNT_WIDTH = 16,
  parameter int ACC_WIDTH   = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic [KIND_W-1:0]       in_kind,
  input  logic                    in_pin_a,
  input  logic                    in_pin_b,
  input  logic                    in_ms_tick,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic signed [OUT_W-1:0] out_flow,
  output logic signed [OUT_W-1:0] out_volume,
  output logic [SES_W-1:0]        out_elapsed,
  output logic                    out_session_end
);

  localparam int DVD_W  = COUNT_WIDTH + FLOW_SCALE_W;
  localparam int VMAG_W = COUNT_WIDTH + VOL_SCALE_W;
  localparam int SUM_W  = ((ACC_WIDTH > VMAG_W) ? ACC_WIDTH : VMAG_W) + 2;
  localparam int MAG_W  = (DVD_W > OUT_W + 1) ? DVD_W : OUT_W + 1;
  localparam int VOL_OW = (ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W;

  localparam logic signed [SUM_W-1:0] ACC_MAX_S =
    {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN_S =
    {{(SUM_W-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [VOL_OW-1:0] V32_MAX = VOL_OW'(signed'({1'b0, I32_MAX}));
  localparam logic signed [VOL_OW-1:0] V32_MIN = VOL_OW'(signed'({1'b1, I32_MIN}));

  logic [WIN_W-1:0]       window_ms_r;
  logic [PPL_W-1:0]       ppl_r;
  logic [SES_W-1:0]       session_ms_r;

  logic                   measuring_r;
  logic                   armed_r;
  logic                   dir_fwd_r;
  logic [COUNT_WIDTH-1:0] fwd_cnt_r;
  logic [COUNT_WIDTH-1:0] rev_cnt_r;
  logic [WIN_W-1:0]       win_el_r;
  logic [SES_W-1:0]       ses_el_r;
  logic signed [ACC_WIDTH-1:0] volume_r;

  logic [COUNT_WIDTH-1:0] c_r;
  logic                   rep_fwd_r;
  logic                   rep_end_r;
  logic [SES_W-1:0]       rep_elapsed_r;
  logic [DVD_W-1:0]       prod_flow_r;
  logic [VMAG_W-1:0]      prod_vol_r;
  logic [DIVISOR_W-1:0]   div_flow_r;
  logic [DVD_W-1:0]       flow_mag_r;
  logic [VMAG_W-1:0]      vol_mag_r;

  logic signed [OUT_W-1:0] out_flow_r;
  logic signed [OUT_W-1:0] out_volume_r;
  logic [SES_W-1:0]        out_elapsed_r;
  logic                    out_end_r;

  logic [WIN_W-1:0]       win_eff;
  logic [PPL_W-1:0]       ppl_eff;
  logic                   armed_upd;
  logic                   dir_upd;
  logic [COUNT_WIDTH-1:0] fwd_upd;
  logic [COUNT_WIDTH-1:0] rev_upd;
  logic [SES_W-1:0]       ses_upd;
  logic [WIN_W:0]         win_upd;
  logic                   win_hit;
  logic                   ses_done;
  logic                   window_end;

  logic [DVD_W-1:0]       div_dividend;
  logic [DIVISOR_W-1:0]   div_divisor;
  logic [DVD_W-1:0]       div_q;
  logic                   div_done;

  logic signed [SUM_W-1:0]  vol_ext;
  logic signed [SUM_W-1:0]  dv_s;
  logic signed [SUM_W-1:0]  vol_sum;
  logic [ACC_WIDTH-1:0]     vol_next;
  logic [MAG_W-1:0]         mag_x;
  logic [OUT_W-1:0]         flow_word;
  logic signed [VOL_OW-1:0] vol_o;
  logic [OUT_W-1:0]         vol_word;

  always_comb begin
    win_eff = (window_ms_r == '0) ? WIN_W'(1) : window_ms_r;
    ppl_eff = (ppl_r == '0) ? PPL_W'(1) : ppl_r;

    armed_upd = armed_r;
    dir_upd   = dir_fwd_r;
    fwd_upd   = fwd_cnt_r;
    rev_upd   = rev_cnt_r;
    if (!in_pin_a && !in_pin_b) begin
      armed_upd = 1'b1;
    end else if (armed_r) begin
      armed_upd = 1'b0;
      if (in_pin_a) begin
        dir_upd = 1'b1;
        if (!(&fwd_cnt_r)) fwd_upd = fwd_cnt_r + COUNT_WIDTH'(1);
      end else begin
        dir_upd = 1'b0;
        if (!(&rev_cnt_r)) rev_upd = rev_cnt_r + COUNT_WIDTH'(1);
      end
    end

    ses_upd    = (&ses_el_r) ? ses_el_r : ses_el_r + SES_W'(1);
    win_upd    = {1'b0, win_el_r} + (WIN_W+1)'(1);
    win_hit    = win_upd >= {1'b0, win_eff};
    ses_done   = ses_upd >= session_ms_r;
    window_end = measuring_r && (in_kind == KIND_SAMPLE) && in_ms_tick && win_hit;

    sts = '{window_end: window_end, div_done: div_done};

    div_dividend = cmd.div_sel_vol ? DVD_W'(prod_vol_r) : prod_flow_r;
    div_divisor  = cmd.div_sel_vol ? DIVISOR_W'(ppl_eff) : div_flow_r;
  end

  bfpm_div #(
    .DVD_W(DVD_W),
    .DVS_W(DIVISOR_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  always_comb begin
    vol_ext = SUM_W'(volume_r);
    dv_s    = signed'(SUM_W'(vol_mag_r));
    vol_sum = rep_fwd_r ? vol_ext + dv_s : vol_ext - dv_s;
    if (vol_sum > ACC_MAX_S) begin
      vol_next = ACC_MAX_S[ACC_WIDTH-1:0];
    end else if (vol_sum < ACC_MIN_S) begin
      vol_next = ACC_MIN_S[ACC_WIDTH-1:0];
    end else begin
      vol_next = vol_sum[ACC_WIDTH-1:0];
    end

    mag_x = MAG_W'(flow_mag_r);
    if (rep_fwd_r) begin
      flow_word = (mag_x > MAG_W'(I32_MAX)) ? I32_MAX : mag_x[OUT_W-1:0];
    end else begin
      flow_word = (mag_x > MAG_W'(I32_MAX)) ? I32_MIN : OUT_W'(0) - mag_x[OUT_W-1:0];
    end

    vol_o = VOL_OW'(volume_r);
    if (vol_o > V32_MAX) begin
      vol_word = I32_MAX;
    end else if (vol_o < V32_MIN) begin
      vol_word = I32_MIN;
    end else begin
      vol_word = vol_o[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ms_r  <= WIN_RST;
      ppl_r        <= PPL_RST;
      session_ms_r <= SES_RST;
      measuring_r  <= 1'b0;
      armed_r      <= 1'b0;
      dir_fwd_r    <= 1'b0;
      fwd_cnt_r    <= '0;
      rev_cnt_r    <= '0;
      win_el_r     <= '0;
      ses_el_r     <= '0;
      volume_r     <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_WINDOW_MS:  window_ms_r  <= cfg_data[WIN_W-1:0];
          CFG_PULSES_PER: ppl_r        <= cfg_data[PPL_W-1:0];
          CFG_SESSION_MS: session_ms_r <= cfg_data[SES_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        case (in_kind)
          KIND_START: begin
            measuring_r <= 1'b1;
            armed_r     <= 1'b0;
            fwd_cnt_r   <= '0;
            rev_cnt_r   <= '0;
            win_el_r    <= '0;
            ses_el_r    <= '0;
            volume_r    <= '0;
          end
          KIND_STOP: measuring_r <= 1'b0;
          KIND_SAMPLE: begin
            if (measuring_r) begin
              dir_fwd_r <= dir_upd;
              if (in_ms_tick) ses_el_r <= ses_upd;
              if (in_ms_tick && win_hit) begin
                armed_r   <= 1'b0;
                fwd_cnt_r <= '0;
                rev_cnt_r <= '0;
                win_el_r  <= '0;
                if (ses_done) measuring_r <= 1'b0;
              end else begin
                armed_r   <= armed_upd;
                fwd_cnt_r <= fwd_upd;
                rev_cnt_r <= rev_upd;
                if (in_ms_tick) win_el_r <= win_upd[WIN_W-1:0];
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd.commit_vol) volume_r <= signed'(vol_next);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && window_end) begin
      c_r           <= dir_upd ? fwd_upd : rev_upd;
      rep_fwd_r     <= dir_upd;
      rep_end_r     <= ses_done;
      rep_elapsed_r <= ses_upd;
    end
    if (cmd.load_mul) begin
      prod_flow_r <= DVD_W'(c_r) * DVD_W'(FLOW_SCALE);
      prod_vol_r  <= VMAG_W'(c_r) * VMAG_W'(VOL_SCALE);
      div_flow_r  <= DIVISOR_W'(win_eff) * DIVISOR_W'(ppl_eff);
    end
    if (cmd.cap_flow) flow_mag_r <= div_q;
    if (cmd.cap_vol) vol_mag_r <= div_q[VMAG_W-1:0];
    if (cmd.emit) begin
      out_flow_r    <= signed'(flow_word);
      out_volume_r  <= signed'(vol_word);
      out_elapsed_r <= rep_elapsed_r;
      out_end_r     <= rep_end_r;
    end
  end

  assign out_flow        = out_flow_r;
  assign out_volume      = out_volume_r;
  assign out_elapsed     = out_elapsed_r;
  assign out_session_end = out_end_r;

endmodule

// File: rtl/bidirectional_flow_pulse_meter_unit.sv
// Top level of the bidirectional turbine flow pulse meter.
// A pin sample, start or stop word is accepted while the unit is idle and needs no
// further work unless it closes a window. A word that closes a window holds
// in_chan.ready low while the one-bit-per-cycle divider, shared between the flow
// quotient and the volume quotient, works out both results, and for as long as the
// previous report still waits on the result channel. Configuration writes are
// always ready and take effect from the cycle after they are written.
module bidirectional_flow_pulse_meter_unit
  import bfpm_pkg::*;
#(
  parameter int COUNT_WIDTH = 16,
  parameter int ACC_WIDTH   = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  bfpm_in_if.sink    in_chan,
  bfpm_out_if.source out_chan,
  bfpm_cfg_if.sink   cfg_chan
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_chan.ready = 1'b1;

  bfpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfpm_dp #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_chan.kind),
    .in_pin_a        (in_chan.pin_a),
    .in_pin_b        (in_chan.pin_b),
    .in_ms_tick      (in_chan.ms_tick),
    .cfg_write       (cfg_chan.valid),
    .cfg_index       (cfg_chan.index),
    .cfg_data        (cfg_chan.data),
    .out_flow        (out_chan.flow_ml_per_s),
    .out_volume      (out_chan.volume_ml),
    .out_elapsed     (out_chan.elapsed_ms),
    .out_session_end (out_chan.session_end)
  );

endmodule

// File: rtl/bfpm_chk.sv
// Port-level checker for the flow pulse meter and its bind to the top level.
module bfpm_chk
  import bfpm_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [KIND_W-1:0]       in_kind,
  input logic                    in_ms_tick,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] out_flow,
  input logic signed [OUT_W-1:0] out_volume,
  input logic [SES_W-1:0]        out_elapsed,
  input logic                    out_session_end
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_flow, out_volume, out_elapsed, out_session_end}))
    else $error("Result word changed or dropped while stalled.");

  a_cmd_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_kind != KIND_SAMPLE |=> in_ready)
    else $error("Start or stop word stalled the input.");

  a_no_tick_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_ms_tick |=> in_ready)
    else $error("Sample without a tick stalled the input.");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !$rose(out_valid))
    else $error("Result appeared one cycle after an accepted word.");

endmodule

bind bidirectional_flow_pulse_meter_unit bfpm_chk u_bfpm_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .in_kind         (in_chan.kind),
  .in_ms_tick      (in_chan.ms_tick),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_flow        (out_chan.flow_ml_per_s),
  .out_volume      (out_chan.volume_ml),
  .out_elapsed     (out_chan.elapsed_ms),
  .out_session_end (out_chan.session_end)
);
